@@ rtl/ljpf_pkg.sv @@
`timescale 1ns / 1ps
package ljpf_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned OutW  = 48;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegEpsilon = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSigma   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScale   = 2'd2;

  localparam logic [63:0] U64Max   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] PosMax48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NegMag48 = 48'h8000_0000_0000;

  // four 32x32 partial products of a 64x64 product: lo*lo, lo*hi, hi*lo, hi*hi
  typedef logic [3:0][63:0] mparts_t;

  function automatic mparts_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    mparts_t p;
    begin
      p[0] = a[31:0] * b[31:0];
      p[1] = a[31:0] * b[63:32];
      p[2] = a[63:32] * b[31:0];
      p[3] = a[63:32] * b[63:32];
      mul_parts = p;
    end
  endfunction

  // sum of partials truncated by k, saturated to 64 bits; sat flag in bit 64
  function automatic logic [64:0] mul_join(input mparts_t p, input int unsigned k);
    logic [127:0] s;
    begin
      s = {64'd0, p[0]} + {32'd0, p[1], 32'd0} + {32'd0, p[2], 32'd0} + {p[3], 64'd0};
      s = s >> k;
      if (s[127:64] != '0) mul_join = {1'b1, U64Max};
      else mul_join = {1'b0, s[63:0]};
    end
  endfunction

  // sign-magnitude to 48-bit two's complement with saturation; flag in bit 48
  function automatic logic [48:0] pack48(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    logic        s;
    logic [47:0] v;
    begin
      m = mag;
      s = 1'b0;
      if (!neg && mag > {16'd0, PosMax48}) begin
        m = {16'd0, PosMax48};
        s = 1'b1;
      end
      if (neg && mag > {16'd0, NegMag48}) begin
        m = {16'd0, NegMag48};
        s = 1'b1;
      end
      v = neg ? (48'd0 - m[47:0]) : m[47:0];
      pack48 = {s, v};
    end
  endfunction

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  // per-item data carried alongside the arithmetic
  typedef struct packed {
    logic [63:0]      rr;
    logic [63:0]      c;
    logic [2:0][63:0] sq;
    logic [2:0][63:0] cr;
    logic [2:0][31:0] m;
    logic [2:0]       ng;
    logic             nf;
    logic             zero;
    logic             ez;
    logic             sat;
    logic [48:0]      epk;
  } ctx_t;

endpackage

@@ rtl/lennard_jones_pair_force.sv @@
`timescale 1ns / 1ps
// Lennard-Jones 12-6 pair energy, gradient on atom A and strain derivative,
// fully pipelined: one atom pair may be started every clock cycle, and its
// result appears marked by done for one cycle. The pipeline has three stages
// for the differences, squares and rr, the two 16-stage dividers (sigma^2/rr
// and DF/rr), nine stages between them (each 64-bit product takes a
// partial-product stage and a sum stage, then one stage for the times-24
// step), and three stages after the second divider for the final products
// and packing. The receiver cannot hold results off, so busy is always low.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no item is in flight; the block does not enforce it.
module lennard_jones_pair_force
  import ljpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]   cfg_data,
  input  logic signed [PosW-1:0] pos_a_x,
  input  logic signed [PosW-1:0] pos_a_y,
  input  logic signed [PosW-1:0] pos_a_z,
  input  logic signed [PosW-1:0] pos_b_x,
  input  logic signed [PosW-1:0] pos_b_y,
  input  logic signed [PosW-1:0] pos_b_z,
  output logic              done,
  output logic signed [OutW-1:0] pair_energy,
  output logic signed [OutW-1:0] grad_x,
  output logic signed [OutW-1:0] grad_y,
  output logic signed [OutW-1:0] grad_z,
  output logic signed [OutW-1:0] strain_xx,
  output logic signed [OutW-1:0] strain_yy,
  output logic signed [OutW-1:0] strain_zz,
  output logic signed [OutW-1:0] strain_xy,
  output logic signed [OutW-1:0] strain_xz,
  output logic signed [OutW-1:0] strain_yz,
  output logic              coincident_or_saturated
);

  logic [31:0] epsilon_energy, sigma_length;
  logic [17:0] pair_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_energy <= '0;
      sigma_length   <= 32'd65536;
      pair_scale     <= 18'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        RegEpsilon: epsilon_energy <= cfg_data;
        RegSigma:   sigma_length   <= cfg_data;
        RegScale:   pair_scale     <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: differences as magnitude and sign; |d| < 2^32 fits 32 bits
  logic        v1;
  logic [31:0] m1 [3];
  logic [2:0]  n1;
  always_ff @(posedge clk) begin
    logic signed [32:0] d;
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    d = 33'(pos_a_x) - 33'(pos_b_x);
    n1[0] <= d[32]; m1[0] <= d[32] ? 32'(-d) : d[31:0];
    d = 33'(pos_a_y) - 33'(pos_b_y);
    n1[1] <= d[32]; m1[1] <= d[32] ? 32'(-d) : d[31:0];
    d = 33'(pos_a_z) - 33'(pos_b_z);
    n1[2] <= d[32]; m1[2] <= d[32] ? 32'(-d) : d[31:0];
  end

  // stage 2: squares and cross products
  logic        v2;
  logic [63:0] sq2 [3];
  logic [63:0] cr2 [3];
  logic [31:0] m2 [3];
  logic [2:0]  n2;
  logic [63:0] s2r, c2r;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int i = 0; i < 3; i++) sq2[i] <= m1[i] * m1[i];
    cr2[0] <= m1[0] * m1[1];
    cr2[1] <= m1[0] * m1[2];
    cr2[2] <= m1[1] * m1[2];
    m2 <= m1;
    n2 <= n1;
    s2r <= sigma_length * sigma_length;
    c2r <= pair_scale * epsilon_energy;
  end

  // stage 3: rr with saturation
  logic        v3, sat3;
  logic [63:0] rr3;
  logic [63:0] cr3 [3];
  logic [63:0] sq3 [3];
  logic [31:0] m3 [3];
  logic [2:0]  n3;
  logic [63:0] s3, c3;
  always_ff @(posedge clk) begin
    logic [65:0] sum;
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    sum = 66'(sq2[0]) + 66'(sq2[1]) + 66'(sq2[2]);
    sat3 <= (sum[65:64] != 2'd0);
    rr3  <= (sum[65:64] != 2'd0) ? U64Max : sum[63:0];
    cr3 <= cr2; sq3 <= sq2; m3 <= m2;
    n3 <= n2; s3 <= s2r; c3 <= c2r;
  end

  // bundle the per-item data that rides along with the first divider
  ctx_t ctx3, ctxA;
  always_comb begin
    ctx3 = '0;
    ctx3.rr = rr3;
    ctx3.c  = c3;
    for (int i = 0; i < 3; i++) begin
      ctx3.sq[i] = sq3[i];
      ctx3.cr[i] = cr3[i];
      ctx3.m[i]  = m3[i];
    end
    ctx3.ng   = n3;
    ctx3.zero = (rr3 == '0);
    ctx3.ez   = (c3 != '0) && (s3 != '0);
    ctx3.sat  = sat3;
  end

  div_req_t reqA;
  assign reqA.num = s3;
  assign reqA.den = (rr3 == '0) ? 64'd1 : rr3;

  logic        dvalid, dsat;
  logic [63:0] rri;
  ljpf_div u_div_a (
    .clk(clk), .rst(rst), .in_valid(v3), .req(reqA), .side_in(ctx3),
    .out_valid(dvalid), .quot(rri), .sat(dsat), .side_out(ctxA)
  );

  // multiply chain: each 64-bit product takes a partial-product stage (a)
  // and a sum stage (b): rri^2, rri^3 = temp, temp^2 = t2, then the energy
  // and force products, then times 24 and the energy pack
  logic        va1, vb1, va2, vb2, va3, vb3, va4, vb4, v5;
  ctx_t        ca1, cb1, ca2, cb2, ca3, cb3, ca4, cb4, c5;
  mparts_t     pa1, pa2, pa3, pe4, pf4;
  logic [63:0] rri_a1, rri_b1, q_b1, temp_b2, temp_a3, temp_b3, t2_b3;
  logic [63:0] e_b4, f_b4, fd5;
  logic        ne_a4, ne_b4;

  always_ff @(posedge clk) begin
    logic [64:0] r;
    logic [64:0] rf;
    logic [63:0] u, dE, dF;
    logic        su, big;
    logic [48:0] ep;
    ctx_t        t;
    if (rst) begin
      va1 <= 1'b0; vb1 <= 1'b0; va2 <= 1'b0; vb2 <= 1'b0; va3 <= 1'b0;
      vb3 <= 1'b0; va4 <= 1'b0; vb4 <= 1'b0; v5 <= 1'b0;
    end else begin
      va1 <= dvalid; vb1 <= va1; va2 <= vb1; vb2 <= va2; va3 <= vb2;
      vb3 <= va3; va4 <= vb3; vb4 <= va4; v5 <= vb4;
    end
    // rri^2
    pa1 <= mul_parts(rri, rri);
    rri_a1 <= rri;
    t = ctxA;
    t.sat = ctxA.sat | (!ctxA.zero & dsat);
    ca1 <= t;
    r = mul_join(pa1, 32);
    t = ca1;
    t.sat = ca1.sat | (!ca1.zero & r[64]);
    cb1 <= t;
    q_b1 <= r[63:0];
    rri_b1 <= rri_a1;
    // temp = rri^3
    pa2 <= mul_parts(q_b1, rri_b1);
    ca2 <= cb1;
    r = mul_join(pa2, 32);
    t = ca2;
    t.sat = ca2.sat | (!ca2.zero & r[64]);
    cb2 <= t;
    temp_b2 <= r[63:0];
    // t2 = temp^2
    pa3 <= mul_parts(temp_b2, temp_b2);
    temp_a3 <= temp_b2;
    ca3 <= cb2;
    r = mul_join(pa3, 32);
    t = ca3;
    t.sat = ca3.sat | (!ca3.zero & r[64]);
    cb3 <= t;
    t2_b3 <= r[63:0];
    temp_b3 <= temp_a3;
    // energy and force differences, then their products with c
    su = t2_b3[63];
    u  = su ? U64Max : {t2_b3[62:0], 1'b0};
    dE = (t2_b3 < temp_b3) ? temp_b3 - t2_b3 : t2_b3 - temp_b3;
    dF = (temp_b3 < u) ? u - temp_b3 : temp_b3 - u;
    pe4 <= mul_parts(cb3.c, dE);
    pf4 <= mul_parts(cb3.c, dF);
    ne_a4 <= t2_b3 < temp_b3;
    t = cb3;
    t.nf  = temp_b3 < u;
    t.sat = cb3.sat | (!cb3.zero & su);
    ca4 <= t;
    r  = mul_join(pe4, 46);
    rf = mul_join(pf4, 32);
    t = ca4;
    t.sat = ca4.sat | (!ca4.zero & (r[64] | rf[64]));
    cb4 <= t;
    e_b4 <= r[63:0];
    f_b4 <= rf[63:0];
    ne_b4 <= ne_a4;
    // times 24 and energy pack
    big = f_b4 > U64Max / 24;
    ep  = pack48(e_b4, ne_b4);
    fd5 <= big ? U64Max : (f_b4 << 4) + (f_b4 << 3);
    t = cb4;
    t.epk = ep;
    t.sat = cb4.sat | (!cb4.zero & (big | ep[48]));
    c5 <= t;
  end

  div_req_t reqB;
  assign reqB.num = fd5;
  assign reqB.den = c5.zero ? 64'd1 : c5.rr;

  logic        v9, dsat9;
  logic [63:0] df9;
  ctx_t        cB;
  ljpf_div u_div_b (
    .clk(clk), .rst(rst), .in_valid(v5), .req(reqB), .side_in(c5),
    .out_valid(v9), .quot(df9), .sat(dsat9), .side_out(cB)
  );

  // final products: partials, then sums
  logic        vf1, vf2;
  ctx_t        cf1, cf2;
  mparts_t     pg [3];
  mparts_t     ps [3];
  mparts_t     px [3];
  logic [63:0] gf [3];
  logic [63:0] sf [3];
  logic [63:0] xf [3];
  logic        ms2;
  always_ff @(posedge clk) begin
    logic [64:0] r;
    logic        s;
    ctx_t        t;
    if (rst) begin
      vf1 <= 1'b0; vf2 <= 1'b0;
    end else begin
      vf1 <= v9; vf2 <= vf1;
    end
    for (int i = 0; i < 3; i++) begin
      pg[i] <= mul_parts(df9, {32'd0, cB.m[i]});
      ps[i] <= mul_parts(df9, cB.sq[i]);
      px[i] <= mul_parts(df9, cB.cr[i]);
    end
    t = cB;
    t.sat = cB.sat | (!cB.zero & dsat9);
    cf1 <= t;
    s = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = mul_join(pg[i], 32); gf[i] <= r[63:0]; s = s | r[64];
      r = mul_join(ps[i], 48); sf[i] <= r[63:0]; s = s | r[64];
      r = mul_join(px[i], 48); xf[i] <= r[63:0]; s = s | r[64];
    end
    ms2 <= s;
    cf2 <= cf1;
  end

  always_ff @(posedge clk) begin
    logic [48:0] p[10];
    logic        s;
    if (rst) done <= 1'b0;
    else done <= vf2;
    p[0] = cf2.epk;
    p[1] = pack48(gf[0], cf2.nf ^ cf2.ng[0]);
    p[2] = pack48(gf[1], cf2.nf ^ cf2.ng[1]);
    p[3] = pack48(gf[2], cf2.nf ^ cf2.ng[2]);
    p[4] = pack48(sf[0], cf2.nf);
    p[5] = pack48(sf[1], cf2.nf);
    p[6] = pack48(sf[2], cf2.nf);
    p[7] = pack48(xf[0], cf2.nf ^ cf2.ng[0] ^ cf2.ng[1]);
    p[8] = pack48(xf[1], cf2.nf ^ cf2.ng[0] ^ cf2.ng[2]);
    p[9] = pack48(xf[2], cf2.nf ^ cf2.ng[1] ^ cf2.ng[2]);
    s = cf2.sat | ms2;
    for (int i = 1; i < 10; i++) s = s | p[i][48];
    if (cf2.zero) begin
      // coincident atoms: zero force, energy pinned at the top if c and sigma^2 are nonzero, else zero
      pair_energy <= cf2.ez ? PosMax48 : '0;
      grad_x <= '0; grad_y <= '0; grad_z <= '0;
      strain_xx <= '0; strain_yy <= '0; strain_zz <= '0;
      strain_xy <= '0; strain_xz <= '0; strain_yz <= '0;
      coincident_or_saturated <= 1'b1;
    end else begin
      pair_energy <= p[0][47:0];
      grad_x <= p[1][47:0]; grad_y <= p[2][47:0]; grad_z <= p[3][47:0];
      strain_xx <= p[4][47:0]; strain_yy <= p[5][47:0]; strain_zz <= p[6][47:0];
      strain_xy <= p[7][47:0]; strain_xz <= p[8][47:0]; strain_yz <= p[9][47:0];
      coincident_or_saturated <= s;
    end
  end

endmodule

@@ rtl/ljpf_div.sv @@
`timescale 1ns / 1ps
// floor(num*2^32/den), restoring, 4 quotient bits per stage, 16 stages
module ljpf_div
  import ljpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  div_req_t    req,
  input  ctx_t        side_in,
  output logic        out_valid,
  output logic [63:0] quot,
  output logic        sat,
  output ctx_t        side_out
);

  localparam int unsigned Stages = 16;
  localparam int unsigned BitsPer = 4;

  logic                  v     [Stages+1];
  logic [64:0]           rem   [Stages+1];
  logic [63:0]           lo    [Stages+1];
  logic [63:0]           q     [Stages+1];
  logic [63:0]           den   [Stages+1];
  logic                  ovf   [Stages+1];
  ctx_t                  side  [Stages+1];

  always_comb begin
    v[0]    = in_valid;
    rem[0]  = {33'd0, req.num[63:32]};
    lo[0]   = {req.num[31:0], 32'd0};
    q[0]    = '0;
    den[0]  = req.den;
    ovf[0]  = ({32'd0, req.num[63:32]} >= req.den);
    side[0] = side_in;
  end

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [64:0] r;
    logic [63:0] l;
    logic [63:0] qq;
    always_comb begin
      r  = rem[g];
      l  = lo[g];
      qq = q[g];
      for (int b = 0; b < BitsPer; b++) begin
        r  = {r[63:0], l[63]};
        l  = {l[62:0], 1'b0};
        qq = {qq[62:0], 1'b0};
        if (r >= {1'b0, den[g]}) begin
          r     = r - {1'b0, den[g]};
          qq[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v[g+1] <= 1'b0;
      else v[g+1] <= v[g];
      rem[g+1]  <= r;
      lo[g+1]   <= l;
      q[g+1]    <= qq;
      den[g+1]  <= den[g];
      ovf[g+1]  <= ovf[g];
      side[g+1] <= side[g];
    end
  end

  assign out_valid = v[Stages];
  assign quot      = ovf[Stages] ? U64Max : q[Stages];
  assign sat       = ovf[Stages];
  assign side_out  = side[Stages];

endmodule

@@ verif/lennard_jones_pair_force_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the Lennard-Jones pair force pipeline.
// Items go in through start/busy, results come back marked by done, one per
// item, in order. A bit-exact predictor computes each result when its item is
// accepted and queues it; the result checker compares every done cycle field
// by field against the oldest queued result.
module lennard_jones_pair_force_tb;
  import ljpf_pkg::*;

  // Index past the register list: the block must ignore writes to it.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned DrainCycles = 60;   // pipeline is 47 deep
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned NumVals     = 10;

  typedef struct {
    logic [NumVals-1:0][47:0] vals;
    logic                     flag;
  } lj_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic signed [PosW-1:0] pos_a_x = '0, pos_a_y = '0, pos_a_z = '0;
  logic signed [PosW-1:0] pos_b_x = '0, pos_b_y = '0, pos_b_z = '0;
  logic done;
  logic signed [OutW-1:0] pair_energy, grad_x, grad_y, grad_z;
  logic signed [OutW-1:0] strain_xx, strain_yy, strain_zz, strain_xy, strain_xz, strain_yz;
  logic coincident_or_saturated;

  // Predictor copy of the register file.
  logic [31:0] eps_reg = 32'd0;
  logic [31:0] sigma_reg = 32'd65536;
  logic [17:0] scale_reg = 18'd65536;

  lj_result_t pending_results[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  logic        pred_sat;
  string       val_names[NumVals] = '{"pair_energy", "grad_x", "grad_y", "grad_z",
      "strain_xx", "strain_yy", "strain_zz", "strain_xy", "strain_xz", "strain_yz"};

  lennard_jones_pair_force uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run in case the pipeline hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  // Exact product shifted right by k, clamped to 64 bits.
  function automatic logic [63:0] prod_trunc(logic [63:0] x, logic [63:0] y, int k);
    logic [127:0] full;
    full = ({64'd0, x} * {64'd0, y}) >> k;
    if (full[127:64] != 0) begin
      pred_sat = 1'b1;
      return U64Max;
    end
    return full[63:0];
  endfunction

  // floor(num * 2^32 / den), clamped to 64 bits; den is never zero here.
  function automatic logic [63:0] quot_q32(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    if ({32'd0, num[63:32]} >= den) begin
      pred_sat = 1'b1;
      return U64Max;
    end
    q = {32'd0, num, 32'd0} / {64'd0, den};
    return q[63:0];
  endfunction

  // Magnitude and sign to a clamped 48-bit two's complement value.
  function automatic logic [47:0] to_q48(logic [63:0] m, logic neg);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    if (m > lim) begin
      pred_sat = 1'b1;
      m = lim;
    end
    return neg ? 48'd0 - m[47:0] : m[47:0];
  endfunction

  function automatic lj_result_t predict_pair(logic [5:0][31:0] pos);
    lj_result_t  r;
    logic signed [32:0] d;
    logic [2:0][63:0] dmag;
    logic [2:0]  dneg;
    logic [65:0] sum_sq;
    logic [63:0] rr, s2, c, rri, temp, t2, twice_t2, diff_e, diff_f, force_q, df;
    logic        neg_e, neg_f;
    pred_sat = 1'b0;
    r.vals = '0;
    r.flag = 1'b0;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({pos[i][31], pos[i]}) - $signed({pos[i+3][31], pos[i+3]});
      dneg[i] = d[32];
      dmag[i] = d[32] ? {31'd0, -d} : {31'd0, d};
      sum_sq += dmag[i] * dmag[i];
    end
    if (sum_sq[65:64] != 0) begin
      rr = U64Max;
      pred_sat = 1'b1;
    end else begin
      rr = sum_sq[63:0];
    end
    s2 = {32'd0, sigma_reg} * {32'd0, sigma_reg};
    c = {46'd0, scale_reg} * {32'd0, eps_reg};
    // Coincident atoms: force undefined, report the flag and a pinned energy.
    if (rr == 0) begin
      r.vals[0] = (c != 0 && s2 != 0) ? PosMax48 : 48'd0;
      r.flag = 1'b1;
      return r;
    end
    rri = quot_q32(s2, rr);
    temp = prod_trunc(prod_trunc(rri, rri, 32), rri, 32);
    t2 = prod_trunc(temp, temp, 32);
    neg_e = t2 < temp;
    diff_e = neg_e ? temp - t2 : t2 - temp;
    r.vals[0] = to_q48(prod_trunc(c, diff_e, 46), neg_e);
    if (t2[63]) begin
      twice_t2 = U64Max;
      pred_sat = 1'b1;
    end else begin
      twice_t2 = t2 << 1;
    end
    neg_f = temp < twice_t2;
    diff_f = neg_f ? twice_t2 - temp : temp - twice_t2;
    force_q = prod_trunc(c, diff_f, 32);
    if (force_q > U64Max / 24) begin
      force_q = U64Max;
      pred_sat = 1'b1;
    end else begin
      force_q = force_q * 24;
    end
    df = quot_q32(force_q, rr);
    for (int i = 0; i < 3; i++) begin
      r.vals[1+i] = to_q48(prod_trunc(df, dmag[i], 32), neg_f ^ dneg[i]);
      r.vals[4+i] = to_q48(prod_trunc(df, dmag[i] * dmag[i], 48), neg_f);
    end
    r.vals[7] = to_q48(prod_trunc(df, dmag[0] * dmag[1], 48), neg_f ^ dneg[0] ^ dneg[1]);
    r.vals[8] = to_q48(prod_trunc(df, dmag[0] * dmag[2], 48), neg_f ^ dneg[0] ^ dneg[2]);
    r.vals[9] = to_q48(prod_trunc(df, dmag[1] * dmag[2], 48), neg_f ^ dneg[1] ^ dneg[2]);
    r.flag = pred_sat;
    return r;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // Sample results at the edge that ends their done cycle.
  always @(posedge clk) begin
    lj_result_t want;
    logic [NumVals-1:0][47:0] got;
    if (!rst && done) begin
      got = {strain_yz, strain_xz, strain_xy, strain_zz, strain_yy, strain_xx,
             grad_z, grad_y, grad_x, pair_energy};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got[0], 48'd0);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < NumVals; i++)
          if (got[i] !== want.vals[i]) report_mismatch(val_names[i], got[i], want.vals[i]);
        if (coincident_or_saturated !== want.flag)
          report_mismatch("coincident_or_saturated", {47'd0, coincident_or_saturated},
                          {47'd0, want.flag});
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  // Present one atom pair after an idle gap, if gap is nonzero, and hold it until accepted.
  task automatic send_pair(logic [5:0][31:0] pos, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pos_a_x <= pos[0];
    pos_a_y <= pos[1];
    pos_a_z <= pos[2];
    pos_b_x <= pos[3];
    pos_b_y <= pos[4];
    pos_b_z <= pos[5];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_pair(pos));
  endtask

  // Mostly short gaps, a few long ones, and runs with no gap at all.
  function automatic int unsigned pick_gap(bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(5, 40);
  endfunction

  // Drain the pipeline, then write one register.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegEpsilon: eps_reg = value;
      RegSigma:   sigma_reg = value;
      RegScale:   scale_reg = value[17:0];
      default: ;
    endcase
  endtask

  task automatic set_params(logic [31:0] eps, logic [31:0] sig, logic [31:0] scl);
    write_reg(RegEpsilon, eps);
    write_reg(RegSigma, sig);
    write_reg(RegScale, scl);
  endtask

  // Pair at offset (dx,dy,dz) from a random origin.
  function automatic logic [5:0][31:0] offset_pair(logic [31:0] dx, logic [31:0] dy,
                                                   logic [31:0] dz);
    logic [5:0][31:0] p;
    p[0] = $urandom;
    p[1] = $urandom;
    p[2] = $urandom;
    p[3] = p[0] - dx;
    p[4] = p[1] - dy;
    p[5] = p[2] - dz;
    return p;
  endfunction

  // Signed offset in [-span, span].
  function automatic logic [31:0] rand_offset(int unsigned span);
    logic [31:0] v;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // ------------------------------------------------------------------- tests
  // Reset registers: epsilon zero, so only rr and the flag matter.
  task automatic test_reset_defaults();
    send_pair(offset_pair(32'h0001_0000, 0, 0), 0);
    send_pair(offset_pair(0, 0, 0), 1);
    send_pair({6{32'h8000_0000}}, 0);
  endtask

  task automatic test_coincident_and_extremes();
    set_params(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pair(offset_pair(0, 0, 0), 0);
    // Opposite corners: every difference at its extreme, rr saturates.
    send_pair({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
    send_pair({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 2);
    send_pair({32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0}, 0);
    // Smallest nonzero distance: huge ratio, saturated outputs.
    send_pair(offset_pair(32'd1, 0, 0), 0);
    send_pair(offset_pair(0, 32'hFFFF_FFFF, 32'd1), 0);
  endtask

  // Distances around sigma: zero energy at sigma, sign changes across it.
  task automatic test_sigma_distance();
    send_pair(offset_pair(32'h0001_0000, 0, 0), 0);
    send_pair(offset_pair(0, 32'hFFFF_0000, 0), 0);
    send_pair(offset_pair(32'h0001_1F5C, 0, 0), 0);
    send_pair(offset_pair(32'h0000_C000, 32'hFFFF_C000, 32'h0000_8000), 3);
    send_pair(offset_pair(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000), 0);
    send_pair(offset_pair(32'h0100_0000, 0, 0), 0);
  endtask

  task automatic test_config_extremes();
    set_params(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0003_FFFF);
    send_pair(offset_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000), 0);
    send_pair(offset_pair(0, 0, 0), 0);
    set_params(32'h0001_0000, 32'd0, 32'd0);
    send_pair(offset_pair(32'h0001_0000, 0, 0), 0);
    send_pair(offset_pair(0, 0, 0), 0);
    // Writes past the register list must leave the registers alone.
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_pair(offset_pair(32'h0002_0000, 0, 0), 0);
  endtask

  // Random pairs under several register settings; most land near sigma.
  task automatic test_random_pairs();
    logic [31:0] eps_set[5] = '{32'h0001_0000, 32'h0000_4000, 32'h00A0_0000,
                                32'hFFFF_FFFF, 32'h0000_0001};
    logic [31:0] sig_set[5] = '{32'h0003_0000, 32'h0001_0000, 32'h0000_8000,
                                32'h0002_4000, 32'hFFFF_FFFF};
    logic [31:0] scl_set[5] = '{32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
                                32'h0000_0001, 32'h0003_FFFF};
    int unsigned span, pick;
    int unsigned burst_left;
    logic [5:0][31:0] p;
    burst_left = 0;
    for (int s = 0; s < 5; s++) begin
      set_params(eps_set[s], sig_set[s], scl_set[s]);
      span = (sig_set[s] > 32'h2000_0000) ? 32'h4000_0000 : sig_set[s] * 2;
      for (int n = 0; n < 165; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          p = offset_pair(rand_offset(span), rand_offset(span), rand_offset(span));
        end else if (pick < 80) begin
          p = offset_pair(rand_offset(3), rand_offset(3), rand_offset(3));
        end else begin
          for (int i = 0; i < 6; i++) p[i] = $urandom;
        end
        if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 30);
        send_pair(p, pick_gap(burst_left != 0));
        if (burst_left != 0) burst_left--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_coincident_and_extremes();
    test_sigma_distance();
    test_config_extremes();
    test_random_pairs();
    start <= 1'b0;
    // Wait out everything in flight, then wait out the drain time for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
